FILE: rtl/core/mmsc_pkg.sv
// Shared widths, register indexes and status types for the masked modular sum checksum.
// No dependencies.
package mmsc_pkg;

	localparam int WORD_W = 64;
	localparam int MOD_W  = 62;
	localparam int DIV_W  = WORD_W + 1;
	localparam int CNT_W  = $clog2(DIV_W + 1);
	localparam int IDX_W  = 1;

	localparam logic [IDX_W-1:0] REG_XOR_MASK = 1'd0;
	localparam logic [IDX_W-1:0] REG_MODULUS  = 1'd1;

	typedef struct packed {
		logic idle;
		logic done;
	} rem_status_t;

endpackage

FILE: rtl/core/mmsc_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle, MSB first.
// Depends on mmsc_pkg.
module mmsc_rem (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [mmsc_pkg::DIV_W-1:0]     dividend,
	input  logic [mmsc_pkg::MOD_W-1:0]     modulus,
	input  logic                           take,
	output mmsc_pkg::rem_status_t          stat,
	output logic [mmsc_pkg::MOD_W-1:0]     remainder
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                        state_q;
	logic [mmsc_pkg::CNT_W-1:0]    cnt_q;
	logic [mmsc_pkg::DIV_W-1:0]    div_q;
	logic [mmsc_pkg::MOD_W-1:0]    rem_q;
	logic [mmsc_pkg::MOD_W:0]      trial;
	logic [mmsc_pkg::MOD_W:0]      diff;
	logic [mmsc_pkg::MOD_W-1:0]    rem_nxt;

	always_comb begin
		trial = {rem_q, div_q[mmsc_pkg::DIV_W-1]};
		diff  = trial - {1'b0, modulus};
		if (trial >= {1'b0, modulus}) begin
			rem_nxt = diff[mmsc_pkg::MOD_W-1:0];
		end else begin
			rem_nxt = trial[mmsc_pkg::MOD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= mmsc_pkg::CNT_W'(mmsc_pkg::DIV_W);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - mmsc_pkg::CNT_W'(1);
					if (cnt_q == mmsc_pkg::CNT_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			div_q <= dividend;
			rem_q <= '0;
		end else if (state_q == ST_RUN) begin
			div_q <= {div_q[mmsc_pkg::DIV_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign remainder = rem_q;

endmodule

FILE: rtl/core/masked_modular_sum_checksum_core.sv
// Masked modular sum checksum core: XOR mask, running modular sum, serial reduction.
// Each accepted word runs through the 65-step bit-serial remainder loop in mmsc_rem; in_stall
// holds further words until that result is taken, which out_stall can also hold off.
// Reset (arst_n low, asynchronous): mask 0, modulus 1, running sum 0, no output pending.
// Depends on mmsc_pkg and mmsc_rem.
module masked_modular_sum_checksum_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mmsc_pkg::IDX_W-1:0]      cfg_index,
	input  logic [mmsc_pkg::WORD_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mmsc_pkg::WORD_W-1:0]     word,
	input  logic                            last_word,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mmsc_pkg::MOD_W-1:0]      checksum,
	output logic                            is_final
);

	logic [mmsc_pkg::WORD_W-1:0]   xor_mask_q;
	logic [mmsc_pkg::MOD_W-1:0]    modulus_q;
	logic [mmsc_pkg::MOD_W-1:0]    mod_eff;
	logic [mmsc_pkg::MOD_W-1:0]    running_sum_q;
	logic                          last_q;
	logic                          out_valid_q;
	logic [mmsc_pkg::MOD_W-1:0]    checksum_q;
	logic                          is_final_q;
	logic                          start;
	logic                          take;
	logic [mmsc_pkg::DIV_W-1:0]    dividend;
	logic [mmsc_pkg::MOD_W-1:0]    remainder;
	mmsc_pkg::rem_status_t         stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_mask_q <= '0;
			modulus_q  <= mmsc_pkg::MOD_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				mmsc_pkg::REG_XOR_MASK: xor_mask_q <= cfg_data;
				mmsc_pkg::REG_MODULUS:  modulus_q  <= cfg_data[mmsc_pkg::MOD_W-1:0];
				default: ;
			endcase
		end
	end

	assign mod_eff  = (modulus_q == '0) ? mmsc_pkg::MOD_W'(1) : modulus_q;
	assign in_stall = !stat.idle;
	assign start    = in_valid && !in_stall;
	assign dividend = mmsc_pkg::DIV_W'(running_sum_q) + mmsc_pkg::DIV_W'(word ^ xor_mask_q);
	assign take     = stat.done && (!out_valid_q || !out_stall);

	mmsc_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.dividend  (dividend),
		.modulus   (mod_eff),
		.take      (take),
		.stat      (stat),
		.remainder (remainder)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (take) begin
				running_sum_q <= last_q ? '0 : remainder;
				out_valid_q   <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			last_q <= last_word;
		end
		if (take) begin
			checksum_q <= remainder;
			is_final_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;
	assign is_final  = is_final_q;

endmodule

FILE: tb/tb_top.sv
// Testbench for masked_modular_sum_checksum_core: directed and random words, random idling on
// both channels, every checksum checked against an in-bench model of the modular sum.
// Depends on mmsc_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;

	typedef struct {
		logic [mmsc_pkg::MOD_W-1:0] checksum;
		logic                       is_final;
	} sum_expect_t;

	class checksum_tracker;
		logic [mmsc_pkg::WORD_W-1:0] mask    = '0;
		logic [mmsc_pkg::MOD_W-1:0]  modulus = 62'd1;
		logic [mmsc_pkg::MOD_W-1:0]  run_sum = '0;
		sum_expect_t                 pending[$];
		int                          failures = 0;
		int                          checked  = 0;
		int                          finals   = 0;

		function void set_reg(logic [mmsc_pkg::IDX_W-1:0] idx,
			logic [mmsc_pkg::WORD_W-1:0] value);
			if (idx == mmsc_pkg::REG_XOR_MASK) begin
				mask = value;
			end else if (idx == mmsc_pkg::REG_MODULUS) begin
				modulus = value[mmsc_pkg::MOD_W-1:0];
			end
		endfunction

		function void note_word(logic [mmsc_pkg::WORD_W-1:0] w, logic lw);
			logic [mmsc_pkg::WORD_W-1:0] m;
			logic [mmsc_pkg::WORD_W-1:0] residue;
			logic [mmsc_pkg::WORD_W-1:0] total;
			sum_expect_t                 e;
			m = (modulus == '0) ? 64'd1 : {2'b00, modulus};
			residue = (w ^ mask) % m;
			total = ({2'b00, run_sum} + residue) % m;
			e.checksum = total[mmsc_pkg::MOD_W-1:0];
			e.is_final = lw;
			pending.push_back(e);
			run_sum = lw ? '0 : total[mmsc_pkg::MOD_W-1:0];
		endfunction

		function void check_result(logic [mmsc_pkg::MOD_W-1:0] cs, logic fin);
			sum_expect_t e;
			if (pending.size() == 0) begin
				$error("unexpected checksum %0h (is_final %0b) with nothing pending", cs, fin);
				failures++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (fin === 1'b1) finals++;
			if (cs !== e.checksum) begin
				$error("checksum: expected %0h, got %0h", e.checksum, cs);
				failures++;
			end
			if (fin !== e.is_final) begin
				$error("is_final: expected %0b, got %0b", e.is_final, fin);
				failures++;
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [mmsc_pkg::IDX_W-1:0]   cfg_index;
	logic [mmsc_pkg::WORD_W-1:0]  cfg_data;
	logic                         in_valid;
	logic                         in_stall;
	logic [mmsc_pkg::WORD_W-1:0]  word;
	logic                         last_word;
	logic                         out_valid;
	logic                         out_stall;
	logic [mmsc_pkg::MOD_W-1:0]   checksum;
	logic                         is_final;

	checksum_tracker tracker;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int words_sent = 0;
	int reg_writes = 0;

	localparam logic [mmsc_pkg::WORD_W-1:0] ALL_ONES = {mmsc_pkg::WORD_W{1'b1}};
	localparam logic [mmsc_pkg::WORD_W-1:0] MOD_MAX  = 64'h3fff_ffff_ffff_ffff;

	masked_modular_sum_checksum_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.word      (word),
		.last_word (last_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.checksum  (checksum),
		.is_final  (is_final)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver: check accepted checksums, stall at random
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) tracker.check_result(checksum, is_final);
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic write_reg(input logic [mmsc_pkg::IDX_W-1:0] idx,
		input logic [mmsc_pkg::WORD_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		tracker.set_reg(idx, value);
		reg_writes++;
	endtask

	task automatic load_settings(input logic [mmsc_pkg::WORD_W-1:0] mask,
		input logic [mmsc_pkg::WORD_W-1:0] m);
		write_reg(mmsc_pkg::REG_XOR_MASK, mask);
		write_reg(mmsc_pkg::REG_MODULUS, m);
		cfg_we <= 1'b0;
	endtask

	task automatic push_word(input logic [mmsc_pkg::WORD_W-1:0] w, input logic lw);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		word <= w;
		last_word <= lw;
		do @(posedge clk); while (!(in_valid && !in_stall));
		tracker.note_word(w, lw);
		words_sent++;
	endtask

	// drop valid and hold until every checksum has come back
	task automatic drain_checksums();
		in_valid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
			default: begin send_idle_pct = 6; recv_stall_pct = 6; end
		endcase
	endtask

	function automatic logic [mmsc_pkg::WORD_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [mmsc_pkg::WORD_W-1:0] pick_modulus();
		case ($urandom_range(7))
			0: return '0;
			1: return 64'd1;
			2: return MOD_MAX;
			3: return 64'($urandom_range(2, 16));
			4: return rand64();
			5: return rand64() & MOD_MAX;
			6: return 64'd1 << $urandom_range(61);
			default: return 64'($urandom());
		endcase
	endfunction

	function automatic logic [mmsc_pkg::WORD_W-1:0] pick_mask();
		case ($urandom_range(3))
			0: return '0;
			1: return ALL_ONES;
			default: return rand64();
		endcase
	endfunction

	function automatic logic [mmsc_pkg::WORD_W-1:0] pick_word();
		logic [mmsc_pkg::WORD_W-1:0] m;
		m = (tracker.modulus == '0) ? 64'd1 : {2'b00, tracker.modulus};
		case ($urandom_range(9))
			6: return '0;
			7: return ALL_ONES;
			8: return tracker.mask ^ 64'($urandom_range(3));
			9: return tracker.mask ^ (m - 64'd1);
			default: return rand64();
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		word = '0;
		last_word = 1'b0;
		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: modulus 1, every checksum zero
		push_word('0, 1'b0);
		push_word(ALL_ONES, 1'b0);
		push_word(64'd123, 1'b1);
		drain_checksums();

		// largest modulus, sum close to the top
		load_settings('0, MOD_MAX);
		push_word('0, 1'b0);
		push_word(ALL_ONES, 1'b0);
		push_word(64'h8000_0000_0000_0000, 1'b0);
		push_word(MOD_MAX, 1'b0);
		push_word(64'h4000_0000_0000_0000, 1'b1);
		drain_checksums();

		// zero modulus acts as one
		load_settings(ALL_ONES, '0);
		push_word(64'h0123_4567_89ab_cdef, 1'b0);
		push_word('0, 1'b1);
		drain_checksums();

		// wide modulus write keeps the low 62 bits
		load_settings(64'h5555_5555_5555_5555, ALL_ONES);
		push_word(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		push_word(ALL_ONES, 1'b0);
		push_word(64'h5555_5555_5555_5555, 1'b1);
		drain_checksums();

		// open run, then shrink the modulus below the running sum
		load_settings(rand64(), 64'd1000);
		repeat (4) push_word(rand64(), 1'b0);
		drain_checksums();
		write_reg(mmsc_pkg::REG_MODULUS, 64'd7);
		cfg_we <= 1'b0;
		push_word(rand64(), 1'b0);
		push_word(rand64(), 1'b1);
		drain_checksums();

		for (int p = 0; p < 16; p++) begin
			set_idling(p % 4);
			load_settings(pick_mask(), pick_modulus());
			for (int i = 0; i < 30; i++) push_word(pick_word(), ($urandom_range(5) == 0));
			drain_checksums();
		end

		repeat (80) @(posedge clk);
		$display("Covered %0d words (%0d closing a run) over %0d register writes;",
			words_sent, tracker.finals, reg_writes);
		$display("%0d checksums compared under four idling patterns.", tracker.checked);
		if (tracker.failures == 0 && tracker.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
